### hw/rtl/utf8_to_glyph_bytes_unit_macros.svh
// Assertion macros shared by the glyph decoder queue and back end
`ifndef UTF8_TO_GLYPH_BYTES_UNIT_MACROS_SVH
`define UTF8_TO_GLYPH_BYTES_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define UTG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define UTG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UTG_ASSERT(name, prop, msg)

`define UTG_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### hw/rtl/utg_pkg.sv
// Shared types, constants and glyph table of the UTF-8 glyph decoder
package utg_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 16;
    localparam int CNT_OUT_W      = 16;
    localparam int CODE_W         = 21;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 byte_valid;
        logic                 run_last;
        logic                 text_end;
        logic                 truncated;
        logic [CNT_OUT_W-1:0] written_count;
    } t_out_item;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] ch;
    } t_glyph;

    typedef struct packed {
        logic [1:0] q_pre;
        logic [1:0] main_len;
        logic [7:0] main_ch;
        logic [1:0] q_post;
        logic       text_end;
    } t_cmd;

    function automatic t_glyph glyph_of(input logic [CODE_W-1:0] code);
        t_glyph g;
        g.len = 2'd1;
        g.ch  = CH_QMARK;
        if (code == 21'h0000A) begin
            g.ch = CH_NL;
        end else if (code >= 21'h00020 && code < 21'h0007F) begin
            g.ch = code[7:0];
        end else if (code < 21'h00020 || code == 21'h0007F) begin
            g.ch = CH_SPACE;
        end else begin
            case (code)
                21'h02018, 21'h02019, 21'h0201A, 21'h0201B,
                21'h02032, 21'h000B4: begin
                    g.ch = CH_APOS;
                end
                21'h0201C, 21'h0201D, 21'h0201E, 21'h0201F,
                21'h02033, 21'h000AB, 21'h000BB: begin
                    g.ch = CH_QUOTE;
                end
                21'h02010, 21'h02011, 21'h02012, 21'h02013,
                21'h02014, 21'h02015, 21'h02212: begin
                    g.ch = CH_DASH;
                end
                21'h02026: begin
                    g.len = 2'd3;
                    g.ch  = CH_DOT;
                end
                21'h000A0, 21'h02007, 21'h02009, 21'h0202F: begin
                    g.ch = CH_SPACE;
                end
                default: begin
                    g.ch = CH_QMARK;
                end
            endcase
        end
        return g;
    endfunction

endpackage

### hw/rtl/utg_front.sv
// Front end: accepts bytes, tracks the pending sequence, emits glyph commands
module utg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utg_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_full,
    output logic              o_push,
    output utg_pkg::t_cmd     o_cmd
);

    logic [utg_pkg::CODE_W-1:0] r_code, n_code;
    logic [1:0]                 r_need, n_need;
    logic [1:0]                 r_held, n_held;

    logic [7:0]                 b;
    logic [utg_pkg::CODE_W-1:0] acc;
    logic [utg_pkg::CODE_W-1:0] gcode;
    logic                       use_glyph;
    logic                       do_start;
    logic                       accept;
    utg_pkg::t_glyph            g;
    utg_pkg::t_cmd              cmd;

    always_comb begin
        b         = i_item.in_byte;
        acc       = {r_code[utg_pkg::CODE_W-7:0], b[5:0]};
        n_code    = r_code;
        n_need    = r_need;
        n_held    = r_held;
        cmd       = '0;
        do_start  = 1'b0;
        use_glyph = 1'b0;
        gcode     = acc;

        if (r_need != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                n_need = r_need - 2'd1;
                n_held = r_held + 2'd1;
                n_code = acc;
                if (r_need == 2'd1) begin
                    use_glyph = 1'b1;
                    n_code    = '0;
                    n_held    = 2'd0;
                end
            end else begin
                cmd.q_pre = r_held;
                n_code    = '0;
                n_need    = 2'd0;
                n_held    = 2'd0;
                do_start  = 1'b1;
            end
        end else begin
            do_start = 1'b1;
        end

        if (do_start) begin
            if (b < 8'h80) begin
                use_glyph = 1'b1;
                gcode     = utg_pkg::CODE_W'(b);
            end else if (b inside {[8'hC2:8'hDF]}) begin
                n_code = utg_pkg::CODE_W'(b[4:0]);
                n_need = 2'd1;
                n_held = 2'd1;
            end else if (b inside {[8'hE0:8'hEF]}) begin
                n_code = utg_pkg::CODE_W'(b[3:0]);
                n_need = 2'd2;
                n_held = 2'd1;
            end else if (b inside {[8'hF0:8'hF4]}) begin
                n_code = utg_pkg::CODE_W'(b[2:0]);
                n_need = 2'd3;
                n_held = 2'd1;
            end else begin
                cmd.main_len = 2'd1;
                cmd.main_ch  = utg_pkg::CH_QMARK;
            end
        end

        g = utg_pkg::glyph_of(gcode);
        if (use_glyph) begin
            cmd.main_len = g.len;
            cmd.main_ch  = g.ch;
        end

        if (i_item.text_last) begin
            if (n_need != 2'd0) begin
                cmd.q_post = n_held;
            end
            cmd.text_end = 1'b1;
            n_code       = '0;
            n_need       = 2'd0;
            n_held       = 2'd0;
        end
    end

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && (|{cmd.q_pre, cmd.main_len, cmd.q_post, cmd.text_end});
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_need <= 2'd0;
            r_held <= 2'd0;
        end else if (accept) begin
            r_code <= n_code;
            r_need <= n_need;
            r_held <= n_held;
        end
    end

endmodule

### hw/rtl/utg_queue.sv
// Command queue between front end and back end
`include "utf8_to_glyph_bytes_unit_macros.svh"

module utg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utg_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output utg_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    utg_pkg::t_cmd               r_mem [utg_pkg::QDEPTH];
    logic [utg_pkg::QPTR_W-1:0]  r_wr;
    logic [utg_pkg::QPTR_W-1:0]  r_rd;
    logic [utg_pkg::QPTR_W:0]    r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (utg_pkg::QPTR_W+1)'(utg_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `UTG_ASSERT(a_no_push_full, i_push |-> !o_full, "push into full queue")
    `UTG_ASSERT(a_no_pop_empty, i_pop |-> !o_empty, "pop from empty queue")
    `UTG_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count slip")

endmodule

### hw/rtl/utg_back.sv
// Back end: expands glyph commands into output bytes under the capacity limit, plus status items
`include "utf8_to_glyph_bytes_unit_macros.svh"

module utg_back #(
    parameter int COUNT_BITS = utg_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [utg_pkg::CAP_W-1:0] i_cap,
    input  utg_pkg::t_cmd             i_cmd,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output utg_pkg::t_out_item        o_item
);

    localparam int LW = (COUNT_BITS > utg_pkg::CAP_W) ? COUNT_BITS : utg_pkg::CAP_W;
    localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_BITS{1'b1}});

    typedef enum logic [2:0] {
        K_QMARK = 3'b001,
        K_MAIN  = 3'b010,
        K_STAT  = 3'b100
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       start;
        logic       piece_end;
        logic [1:0] size;
    } t_slot;

    function automatic t_slot decode_slot(input utg_pkg::t_cmd c, input logic [3:0] p);
        logic [3:0] p2;
        logic [3:0] p3;
        t_slot      s;
        s.kind      = K_STAT;
        s.start     = 1'b1;
        s.piece_end = 1'b1;
        s.size      = 2'd1;
        p2 = p - 4'(c.q_pre);
        p3 = p2 - 4'(c.main_len);
        if (p < 4'(c.q_pre)) begin
            s.kind = K_QMARK;
        end else if (p2 < 4'(c.main_len)) begin
            s.kind      = K_MAIN;
            s.start     = (p2 == 4'd0);
            s.piece_end = (p2 == 4'(c.main_len) - 4'd1);
            s.size      = c.main_len;
        end else if (p3 < 4'(c.q_post)) begin
            s.kind = K_QMARK;
        end
        return s;
    endfunction

    logic [3:0]            r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_written, n_written;
    logic                  r_stopped, n_stopped;
    logic                  r_out_valid, n_out_valid;
    utg_pkg::t_out_item    r_out, n_out;

    logic [LW-1:0]         limit;
    logic [3:0]            tot;
    logic [3:0]            pos_inc;
    logic                  is_final;
    logic                  fire;
    logic                  emit;
    logic                  fits_cur;
    logic                  fits_nxt;
    logic [LW:0]           sum_cur;
    logic [LW:0]           sum_nxt;
    t_slot                 cur;
    t_slot                 nxt;
    utg_pkg::t_out_item    item;

    assign limit = (LW'(i_cap) < CNT_MAX) ? LW'(i_cap) : CNT_MAX;

    always_comb begin
        tot      = 4'(i_cmd.q_pre) + 4'(i_cmd.main_len) + 4'(i_cmd.q_post)
                 + 4'(i_cmd.text_end);
        pos_inc  = r_pos + 4'd1;
        is_final = (pos_inc == tot);
        fire     = !i_empty && (!r_out_valid || !i_stall);
        cur      = decode_slot(i_cmd, r_pos);
        nxt      = decode_slot(i_cmd, pos_inc);
        sum_cur  = (LW+1)'(r_written) + (LW+1)'(cur.size);
        sum_nxt  = (LW+1)'(r_written) + (LW+1)'(nxt.size) + (LW+1)'(1);
        fits_cur = (sum_cur <= (LW+1)'(limit));
        fits_nxt = (sum_nxt <= (LW+1)'(limit));

        emit      = 1'b0;
        item      = '0;
        n_written = r_written;
        n_stopped = r_stopped;

        case (cur.kind)
            K_STAT: begin
                emit               = 1'b1;
                item.text_end      = 1'b1;
                item.run_last      = 1'b1;
                item.truncated     = r_stopped;
                item.written_count = utg_pkg::CNT_OUT_W'(r_written);
                n_written          = '0;
                n_stopped          = 1'b0;
            end
            K_QMARK, K_MAIN: begin
                if (cur.start) begin
                    emit = !r_stopped && fits_cur;
                    if (!r_stopped && !fits_cur) begin
                        n_stopped = 1'b1;
                    end
                end else begin
                    emit = !r_stopped;
                end
                item.out_byte      = (cur.kind == K_MAIN) ? i_cmd.main_ch : utg_pkg::CH_QMARK;
                item.byte_valid    = 1'b1;
                item.run_last      = !i_cmd.text_end && cur.piece_end && (is_final || !fits_nxt);
                item.written_count = utg_pkg::CNT_OUT_W'(r_written + COUNT_BITS'(1));
                if (emit) begin
                    n_written = r_written + COUNT_BITS'(1);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        if (!fire) begin
            n_written = r_written;
            n_stopped = r_stopped;
        end

        n_pos       = fire ? (is_final ? 4'd0 : pos_inc) : r_pos;
        n_out_valid = fire ? emit : (r_out_valid && i_stall);
        n_out       = (fire && emit) ? item : r_out;
    end

    assign o_pop   = fire && is_final;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 4'd0;
            r_written   <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_written   <= n_written;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    `UTG_ASSERT(a_status_closes, r_out_valid && r_out.text_end |-> r_out.run_last && !r_out.byte_valid, "status item malformed")
    `UTG_ASSERT(a_count_in_limit, r_out_valid && r_out.byte_valid |-> LW'(r_out.written_count) <= limit, "byte past capacity")
    `UTG_ASSERT_NEXT(a_stop_sticky, r_stopped && !(fire && cur.kind == K_STAT), r_stopped, "stop flag dropped early")

endmodule

### hw/rtl/utf8_to_glyph_bytes_unit.sv
// Top level of the UTF-8 to drawable ASCII glyph decoder
//
// Input channel (i_in_valid, o_in_stall, i_in_item): one UTF-8 byte per transfer,
// text_last set on the final byte of a text.
// Output channel (o_out_valid, i_out_stall, o_out_item): glyph bytes, and one
// status item (byte_valid low, text_end high) after the last byte of each text.
// Config channel (i_cfg_valid, o_cfg_ready, i_cfg_data): output capacity per text;
// always ready, write only while the block is idle.
// Path: a transferred byte is decoded combinationally and its command is pushed
// into the command queue; the back end registers each output item.
// Throughput: one byte per cycle while each byte needs at most one back-end slot
// and the receiver does not stall. A glyph command occupies the back end slot by
// slot (held '?', glyph byte, status), slots dropped at capacity included; a byte
// that yields no command skips it. A four-entry command queue absorbs bursts.
// Reset clears the decode state, byte count, stop flag and queue; capacity
// returns to 4096. When the receiver stalls, the output register holds, the
// queue fills, and o_in_stall rises once it is full.
module utf8_to_glyph_bytes_unit #(
    parameter int COUNT_BITS = utg_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  utg_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output utg_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [utg_pkg::CAP_W-1:0] i_cfg_data
);

    logic [utg_pkg::CAP_W-1:0] r_out_capacity;

    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    utg_pkg::t_cmd push_cmd;
    utg_pkg::t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= utg_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_out_capacity <= i_cfg_data;
        end
    end

    utg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    utg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    utg_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_out_capacity),
        .i_cmd   (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
